// ===== src/ppfe_pkg.sv =====
package ppfe_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;

  localparam logic [7:0]  ADDRESS_RESET  = 8'hFF;
  localparam logic [7:0]  CONTROL_RESET  = 8'h03;
  localparam logic [15:0] PROTOCOL_RESET = 16'hC021;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL = 2'd2;

  // One frame request as it waits between the front and the back.
  typedef struct packed {
    logic [15:0] payload;
    logic [15:0] fcs;
    logic        esc_hi;
    logic        esc_lo;
  } frame_req_t;

  typedef enum logic [11:0] {
    ST_FLAG_OPEN  = 12'b0000_0000_0001,
    ST_ADDR       = 12'b0000_0000_0010,
    ST_CTRL       = 12'b0000_0000_0100,
    ST_PROT_HI    = 12'b0000_0000_1000,
    ST_PROT_LO    = 12'b0000_0001_0000,
    ST_ESC_HI     = 12'b0000_0010_0000,
    ST_DATA_HI    = 12'b0000_0100_0000,
    ST_ESC_LO     = 12'b0000_1000_0000,
    ST_DATA_LO    = 12'b0001_0000_0000,
    ST_FCS_HI     = 12'b0010_0000_0000,
    ST_FCS_LO     = 12'b0100_0000_0000,
    ST_FLAG_CLOSE = 12'b1000_0000_0000
  } byte_state_t;

  // Sixteen-bit ones' complement addition with end-around carry.
  function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

// ===== src/ppp_style_frame_encoder.sv =====
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_push / in_full   | in_payload[15:0]
// out_     | output    | out_empty / out_pop | out_byte[7:0], out_last
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// Each payload word produces a frame of 10 to 12 bytes; the byte sequencer in the
// back end emits them one byte per cycle while out_pop keeps the output drained.
// The front end computes the checksum and escape flags in the cycle of the push.
// A queue of QUEUE_DEPTH requests decouples the two; in_full rises when it fills.
// Reset is synchronous and active low; it restores the register defaults.
module ppp_style_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [15:0]                        in_payload,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [7:0]                         out_byte,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [7:0]  address_r, address_nxt;
  logic [7:0]  control_r, control_nxt;
  logic [15:0] protocol_r, protocol_nxt;

  logic                 q_wr;
  logic                 q_rd;
  logic                 q_full;
  logic                 q_valid;
  ppfe_pkg::frame_req_t q_wr_req;
  ppfe_pkg::frame_req_t q_rd_req;

  assign cfg_ready = 1'b1;

  always_comb begin
    address_nxt  = address_r;
    control_nxt  = control_r;
    protocol_nxt = protocol_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppfe_pkg::CFG_ADDRESS:  address_nxt  = cfg_data[7:0];
        ppfe_pkg::CFG_CONTROL:  control_nxt  = cfg_data[7:0];
        ppfe_pkg::CFG_PROTOCOL: protocol_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r  <= ppfe_pkg::ADDRESS_RESET;
      control_r  <= ppfe_pkg::CONTROL_RESET;
      protocol_r <= ppfe_pkg::PROTOCOL_RESET;
    end else begin
      address_r  <= address_nxt;
      control_r  <= control_nxt;
      protocol_r <= protocol_nxt;
    end
  end

  ppfe_front u_front (
    .clk          (clk),
    .address_nxt  (rst_n ? address_nxt : ppfe_pkg::ADDRESS_RESET),
    .control_nxt  (rst_n ? control_nxt : ppfe_pkg::CONTROL_RESET),
    .protocol_nxt (rst_n ? protocol_nxt : ppfe_pkg::PROTOCOL_RESET),
    .in_push      (in_push),
    .in_payload   (in_payload),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wr_req     (q_wr_req)
  );

  ppfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wr_req    (q_wr_req),
    .rd        (q_rd),
    .rd_req    (q_rd_req),
    .full      (q_full),
    .not_empty (q_valid)
  );

  ppfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .address_r  (address_r),
    .control_r  (control_r),
    .protocol_r (protocol_r),
    .q_valid    (q_valid),
    .q_req      (q_rd_req),
    .q_rd       (q_rd),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  assign in_full = q_full;

`ifndef ASSERT_OFF
  a_last_is_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (out_byte == ppfe_pkg::FLAG_BYTE))
    else $error("closing byte is not a flag");

  a_full_after_push : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("queue filled without a request");

  a_out_from_queue : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(q_valid))
    else $error("byte produced with no request queued");
`endif

endmodule

// ===== src/ppfe_front.sv =====
module ppfe_front (
  input  logic                   clk,
  input  logic [7:0]             address_nxt,
  input  logic [7:0]             control_nxt,
  input  logic [15:0]            protocol_nxt,
  input  logic                   in_push,
  input  logic [15:0]            in_payload,
  input  logic                   q_full,
  output logic                   q_wr,
  output ppfe_pkg::frame_req_t   q_wr_req
);

  // The header part of the checksum follows the configuration registers.
  logic [15:0] hdr_sum_r;
  logic [15:0] hdr_sum_nxt;

  assign hdr_sum_nxt = ppfe_pkg::eac_add({address_nxt, control_nxt}, protocol_nxt);

  always_ff @(posedge clk) begin
    hdr_sum_r <= hdr_sum_nxt;
  end

  assign q_wr = in_push && !q_full;

  always_comb begin
    q_wr_req.payload = in_payload;
    q_wr_req.fcs     = ~ppfe_pkg::eac_add(hdr_sum_r, in_payload);
    q_wr_req.esc_hi  = ppfe_pkg::needs_escape(in_payload[15:8]);
    q_wr_req.esc_lo  = ppfe_pkg::needs_escape(in_payload[7:0]);
  end

endmodule

// ===== src/ppfe_fifo.sv =====
module ppfe_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  ppfe_pkg::frame_req_t wr_req,
  input  logic                 rd,
  output ppfe_pkg::frame_req_t rd_req,
  output logic                 full,
  output logic                 not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ppfe_pkg::frame_req_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_req    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_req;
    end
  end

endmodule

// ===== src/ppfe_back.sv =====
module ppfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           address_r,
  input  logic [7:0]           control_r,
  input  logic [15:0]          protocol_r,
  input  logic                 q_valid,
  input  ppfe_pkg::frame_req_t q_req,
  output logic                 q_rd,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  ppfe_pkg::byte_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic       advance;

  assign advance = q_valid && (!out_valid_r || out_pop);

  always_comb begin
    byte_sel  = ppfe_pkg::FLAG_BYTE;
    last_sel  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ppfe_pkg::ST_FLAG_OPEN: begin
        byte_sel  = ppfe_pkg::FLAG_BYTE;
        state_nxt = ppfe_pkg::ST_ADDR;
      end
      ppfe_pkg::ST_ADDR: begin
        byte_sel  = address_r;
        state_nxt = ppfe_pkg::ST_CTRL;
      end
      ppfe_pkg::ST_CTRL: begin
        byte_sel  = control_r;
        state_nxt = ppfe_pkg::ST_PROT_HI;
      end
      ppfe_pkg::ST_PROT_HI: begin
        byte_sel  = protocol_r[15:8];
        state_nxt = ppfe_pkg::ST_PROT_LO;
      end
      ppfe_pkg::ST_PROT_LO: begin
        byte_sel  = protocol_r[7:0];
        state_nxt = q_req.esc_hi ? ppfe_pkg::ST_ESC_HI : ppfe_pkg::ST_DATA_HI;
      end
      ppfe_pkg::ST_ESC_HI: begin
        byte_sel  = ppfe_pkg::ESC_BYTE;
        state_nxt = ppfe_pkg::ST_DATA_HI;
      end
      ppfe_pkg::ST_DATA_HI: begin
        byte_sel  = q_req.payload[15:8];
        state_nxt = q_req.esc_lo ? ppfe_pkg::ST_ESC_LO : ppfe_pkg::ST_DATA_LO;
      end
      ppfe_pkg::ST_ESC_LO: begin
        byte_sel  = ppfe_pkg::ESC_BYTE;
        state_nxt = ppfe_pkg::ST_DATA_LO;
      end
      ppfe_pkg::ST_DATA_LO: begin
        byte_sel  = q_req.payload[7:0];
        state_nxt = ppfe_pkg::ST_FCS_HI;
      end
      ppfe_pkg::ST_FCS_HI: begin
        byte_sel  = q_req.fcs[15:8];
        state_nxt = ppfe_pkg::ST_FCS_LO;
      end
      ppfe_pkg::ST_FCS_LO: begin
        byte_sel  = q_req.fcs[7:0];
        state_nxt = ppfe_pkg::ST_FLAG_CLOSE;
      end
      ppfe_pkg::ST_FLAG_CLOSE: begin
        byte_sel  = ppfe_pkg::FLAG_BYTE;
        last_sel  = 1'b1;
        state_nxt = ppfe_pkg::ST_FLAG_OPEN;
      end
      default: begin
        state_nxt = ppfe_pkg::ST_FLAG_OPEN;
      end
    endcase
  end

  assign q_rd = advance && (state_r == ppfe_pkg::ST_FLAG_CLOSE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppfe_pkg::ST_FLAG_OPEN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== tb/ppfe_frame_monitor.sv =====
`timescale 1ns / 1ps

module ppfe_frame_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  logic [15:0]                      in_payload,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  logic [7:0]                       out_byte,
  input  logic                             out_last,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ppfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      mismatches,
  output int unsigned                      bytes_due
);

  typedef struct packed {
    logic [7:0] value;
    logic       closing;
  } wire_byte_t;

  wire_byte_t  frame_bytes_due[$];
  logic [7:0]  address_reg  = ppfe_pkg::ADDRESS_RESET;
  logic [7:0]  control_reg  = ppfe_pkg::CONTROL_RESET;
  logic [15:0] protocol_reg = ppfe_pkg::PROTOCOL_RESET;

  initial begin
    mismatches = 0;
    bytes_due  = 0;
  end

  // The three words are summed in full and the carries folded back twice, which gives
  // the same result as adding them one at a time with end-around carry.
  function automatic logic [15:0] frame_check_word(input logic [15:0] payload);
    logic [17:0] total;
    total = {2'b00, address_reg, control_reg} + {2'b00, protocol_reg} + {2'b00, payload};
    total = {2'b00, total[15:0]} + {16'd0, total[17:16]};
    total = {2'b00, total[15:0]} + {16'd0, total[17:16]};
    return ~total[15:0];
  endfunction

  task automatic queue_byte(input logic [7:0] value, input logic closing);
    wire_byte_t entry;
    entry.value   = value;
    entry.closing = closing;
    frame_bytes_due.push_back(entry);
  endtask

  task automatic queue_payload_byte(input logic [7:0] value);
    if (value == ppfe_pkg::FLAG_BYTE || value == ppfe_pkg::ESC_BYTE) begin
      queue_byte(ppfe_pkg::ESC_BYTE, 1'b0);
    end
    queue_byte(value, 1'b0);
  endtask

  task automatic encode_frame(input logic [15:0] payload);
    logic [15:0] fcs;
    fcs = frame_check_word(payload);
    queue_byte(ppfe_pkg::FLAG_BYTE, 1'b0);
    queue_byte(address_reg, 1'b0);
    queue_byte(control_reg, 1'b0);
    queue_byte(protocol_reg[15:8], 1'b0);
    queue_byte(protocol_reg[7:0], 1'b0);
    queue_payload_byte(payload[15:8]);
    queue_payload_byte(payload[7:0]);
    queue_byte(fcs[15:8], 1'b0);
    queue_byte(fcs[7:0], 1'b0);
    queue_byte(ppfe_pkg::FLAG_BYTE, 1'b1);
  endtask

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    wire_byte_t due;
    if (!rst_n) begin
      address_reg  = ppfe_pkg::ADDRESS_RESET;
      control_reg  = ppfe_pkg::CONTROL_RESET;
      protocol_reg = ppfe_pkg::PROTOCOL_RESET;
      frame_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppfe_pkg::CFG_ADDRESS:  address_reg  = cfg_data[7:0];
          ppfe_pkg::CFG_CONTROL:  control_reg  = cfg_data[7:0];
          ppfe_pkg::CFG_PROTOCOL: protocol_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        encode_frame(in_payload);
      end
      if (out_pop && !out_empty) begin
        if (frame_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("byte %02h arrived with no frame byte due", out_byte));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_byte !== due.value) begin
            flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, due.value));
          end
          if (out_last !== due.closing) begin
            flag_mismatch($sformatf("out_last %b on byte %02h, expected %b",
                                    out_last, out_byte, due.closing));
          end
        end
      end
    end
    bytes_due <= frame_bytes_due.size();
  end

endmodule

// ===== tb/ppp_style_frame_encoder_tb.sv =====
`timescale 1ns / 1ps

module ppp_style_frame_encoder_tb;

  localparam logic [ppfe_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 80;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_push    = 1'b0;
  logic                             in_full;
  logic [15:0]                      in_payload = '0;
  logic                             out_empty;
  logic                             out_pop    = 1'b0;
  logic [7:0]                       out_byte;
  logic                             out_last;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [ppfe_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [ppfe_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  int unsigned mismatches;
  int unsigned bytes_due;
  bit          calm         = 1'b0;
  int unsigned pop_left     = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ppp_style_frame_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_payload (in_payload),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ppfe_frame_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_payload (in_payload),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .bytes_due  (bytes_due)
  );

  always @(posedge clk) begin
    if (calm) begin
      out_pop <= 1'b1;
    end else if (pop_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_pop  <= 1'b0;
        pop_left <= $urandom_range(1, 14);
      end else begin
        out_pop  <= 1'b1;
        pop_left <= $urandom_range(1, 30);
      end
    end else begin
      pop_left <= pop_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_wire_byte();
    logic [7:0] value;
    case ($urandom_range(0, 7))
      0, 1:    value = ppfe_pkg::FLAG_BYTE;
      2:       value = ppfe_pkg::ESC_BYTE;
      default: value = 8'($urandom_range(0, 255));
    endcase
    return value;
  endfunction

  task automatic send_word(input logic [15:0] word);
    in_push    <= 1'b1;
    in_payload <= word;
    do @(posedge clk); while (in_full !== 1'b0);
  endtask

  task automatic hold_off(input int unsigned cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ppfe_pkg::CFG_INDEX_W-1:0] index,
                           input logic [ppfe_pkg::CFG_DATA_W-1:0]  data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Header bytes are written with random upper bits, which the block must drop.
  task automatic apply_setting(input logic [7:0] address, input logic [7:0] control,
                               input logic [15:0] protocol);
    logic [7:0]  junk_a;
    logic [7:0]  junk_c;
    logic [15:0] junk_spare;
    junk_a     = 8'($urandom_range(0, 255));
    junk_c     = 8'($urandom_range(0, 255));
    junk_spare = 16'($urandom_range(0, 65535));
    write_reg(CFG_UNUSED, junk_spare);
    write_reg(ppfe_pkg::CFG_ADDRESS, {junk_a, address});
    write_reg(ppfe_pkg::CFG_CONTROL, {junk_c, control});
    write_reg(ppfe_pkg::CFG_PROTOCOL, protocol);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned words);
    for (int unsigned n = 0; n < words; n++) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold_off($urandom_range(1, 14));
      end
      if (!calm && $urandom_range(0, 59) == 0) begin
        drain();
      end
      send_word({pick_wire_byte(), pick_wire_byte()});
    end
    drain();
  endtask

  initial begin
    logic [15:0] corner_words [10];
    corner_words = '{16'h0000, 16'hFFFF, 16'h7E7E, 16'h7D7D, 16'h7E7D,
                     16'h7D7E, 16'h7E00, 16'h007D, 16'h8001, 16'h40FC};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_words[i]) begin
      send_word(corner_words[i]);
    end
    drain();

    apply_setting(8'h00, 8'h00, 16'h0000);
    send_word(16'h0000);
    send_word(16'hFFFF);
    drain();

    apply_setting(8'hFF, 8'hFF, 16'hFFFF);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h7E7D);
    drain();

    // Header bytes that look like flags or escapes go out unstuffed.
    apply_setting(ppfe_pkg::FLAG_BYTE, ppfe_pkg::ESC_BYTE,
                  {ppfe_pkg::ESC_BYTE, ppfe_pkg::FLAG_BYTE});
    send_word(16'h7D7E);
    send_word(16'h1234);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        calm <= 1'b1;
      end
      apply_setting(pick_wire_byte(), pick_wire_byte(), {pick_wire_byte(), pick_wire_byte()});
      run_phase(PHASE_WORDS);
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ppfe_pkg.sv
src/ppfe_front.sv
src/ppfe_fifo.sv
src/ppfe_back.sv
src/ppp_style_frame_encoder.sv
tb/ppfe_frame_monitor.sv
tb/ppp_style_frame_encoder_tb.sv
